FILE: sv/pdts_pkg.sv
package pdts_pkg;

    localparam int FPS_W   = 10;
    localparam int DLY_W   = 24;
    localparam int IV_W    = 20;
    localparam int DEN_W   = 25;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 16;
    localparam int CORR_W  = 21;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // serial divider: remainder as wide as the largest divisor, quotient as the interval
    localparam int QW         = 20;
    localparam int STEP_W     = 5;
    localparam int RATE_FRAC  = 16;

    localparam logic [STEP_W-1:0] IV_STEPS   = STEP_W'(QW);
    localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(RATE_FRAC);
    localparam logic [QW-1:0]     US_PER_S   = QW'(1000000);
    localparam logic [RATE_W-1:0] RATE_SAT   = '1;

    // x / 3 == (x * RECIP3) >> RECIP3_SH for x below 2^21
    localparam int                RECIP3_SH = 23;
    localparam logic [21:0]       RECIP3    = 22'd2796203;

    localparam int MIN_GAP = 2;

    localparam logic [RATE_W-1:0] TH_30  = RATE_W'(30);
    localparam logic [RATE_W-1:0] TH_50  = RATE_W'(50);
    localparam logic [RATE_W-1:0] TH_70  = RATE_W'(70);
    localparam logic [RATE_W-1:0] TH_80  = RATE_W'(80);
    localparam logic [RATE_W-1:0] TH_90  = RATE_W'(90);
    localparam logic [RATE_W-1:0] TH_110 = RATE_W'(110);
    localparam logic [RATE_W-1:0] TH_120 = RATE_W'(120);
    localparam logic [RATE_W-1:0] TH_130 = RATE_W'(130);
    localparam logic [RATE_W-1:0] TH_150 = RATE_W'(150);
    localparam logic [RATE_W-1:0] TH_250 = RATE_W'(250);

    typedef enum logic {
        REG_FPS   = 1'b0,
        REG_DELAY = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        B_UP1,
        B_UP2,
        B_UP3,
        B_UP4,
        B_UP8,
        B_HOLD,
        B_DN8,
        B_DN4,
        B_DN3,
        B_DN23,
        B_DN34
    } t_band;

    typedef struct packed {
        logic load;
        logic iv_start;
        logic mul;
        logic scale;
        logic rate_start;
        logic corr;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic t_band band_of(input logic [RATE_W-1:0] rate);
        t_band b;
        if (rate < TH_30) begin
            b = B_UP1;
        end else if (rate < TH_50) begin
            b = B_UP2;
        end else if (rate < TH_70) begin
            b = B_UP3;
        end else if (rate < TH_80) begin
            b = B_UP4;
        end else if (rate < TH_90) begin
            b = B_UP8;
        end else if (rate < TH_110) begin
            b = B_HOLD;
        end else if (rate < TH_120) begin
            b = B_DN8;
        end else if (rate < TH_130) begin
            b = B_DN4;
        end else if (rate < TH_150) begin
            b = B_DN3;
        end else if (rate < TH_250) begin
            b = B_DN23;
        end else begin
            b = B_DN34;
        end
        return b;
    endfunction

endpackage

FILE: sv/pdts_div.sv
module pdts_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pdts_pkg::STEP_W-1:0]      i_steps,
    input  logic [pdts_pkg::DEN_W-1:0]       i_rem_init,
    input  logic [pdts_pkg::QW-1:0]          i_quo_init,
    input  logic [pdts_pkg::DEN_W-1:0]       i_divisor,
    output logic                             o_busy,
    output logic [pdts_pkg::QW-1:0]          o_quo
);

    logic [pdts_pkg::STEP_W-1:0] r_cnt;
    logic [pdts_pkg::DEN_W-1:0]  r_rem;
    logic [pdts_pkg::QW-1:0]     r_quo;
    logic [pdts_pkg::DEN_W-1:0]  r_dvs;

    logic [pdts_pkg::DEN_W:0]    trial;
    logic [pdts_pkg::DEN_W:0]    diff;
    logic                        ge;

    // restoring step: shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_quo[pdts_pkg::QW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_quo <= i_quo_init;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[pdts_pkg::DEN_W-1:0] : trial[pdts_pkg::DEN_W-1:0];
            r_quo <= {r_quo[pdts_pkg::QW-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

FILE: sv/pdts_ctrl.sv
module pdts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pdts_pkg::t_stat  i_stat,
    output pdts_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_IV_DIV     = 8'b0000_0010,
        S_MUL        = 8'b0000_0100,
        S_SCALE      = 8'b0000_1000,
        S_RATE_START = 8'b0001_0000,
        S_RATE_DIV   = 8'b0010_0000,
        S_CORR       = 8'b0100_0000,
        S_SCHED      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.iv_start = 1'b1;
                    n_state        = S_IV_DIV;
                end
            end
            S_IV_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RATE_START;
            end
            S_RATE_START: begin
                o_cmd.rate_start = 1'b1;
                n_state          = S_RATE_DIV;
            end
            S_RATE_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_CORR;
                end
            end
            S_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = S_SCHED;
            end
            S_SCHED: begin
                // hold until the output register can take the item
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: sv/pdts_dpath.sv
module pdts_dpath #(
    parameter int SEQ_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pdts_pkg::t_cmd                       i_cmd,
    output pdts_pkg::t_stat                      o_stat,
    input  logic [pdts_pkg::FPS_W-1:0]           i_fps,
    input  logic [pdts_pkg::DLY_W-1:0]           i_delay,
    input  logic                                 i_restart,
    input  logic [pdts_pkg::TIME_W-1:0]          i_present_time_us,
    input  logic [SEQ_BITS-1:0]                  i_current_seq,
    input  logic                                 i_current_seq_valid,
    input  logic [SEQ_BITS-1:0]                  i_newest_seq,
    input  logic [pdts_pkg::RATE_W-1:0]          i_fill_rate_in,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [pdts_pkg::TIME_W-1:0]          o_next_time_us,
    output logic signed [pdts_pkg::CORR_W-1:0]   o_correction_us,
    output logic                                 o_scheduled,
    output logic [pdts_pkg::RATE_W-1:0]          o_fill_rate_out
);

    localparam int IV_W   = pdts_pkg::IV_W;
    localparam int DEN_W  = pdts_pkg::DEN_W;
    localparam int TIME_W = pdts_pkg::TIME_W;
    localparam int CORR_W = pdts_pkg::CORR_W;
    localparam int RATE_W = pdts_pkg::RATE_W;
    localparam int QW     = pdts_pkg::QW;
    localparam int FRAC   = pdts_pkg::RATE_FRAC;
    localparam int DMW    = SEQ_BITS - 1;
    localparam int PRW    = DMW + IV_W;
    localparam int NUMW   = PRW + 7;
    localparam int HIW    = NUMW - FRAC;
    localparam int CMPW   = (HIW > DEN_W) ? HIW : DEN_W;
    localparam int P3W    = 43;

    // item fields
    logic                      r_restart;
    logic [TIME_W-1:0]         r_present;
    logic [SEQ_BITS-1:0]       r_cur;
    logic                      r_cur_valid;
    logic [RATE_W-1:0]         r_fill;
    logic [DMW-1:0]            r_dmag;
    logic                      r_rate_zero;

    // working registers
    logic [IV_W-1:0]           r_interval;
    logic [PRW-1:0]            r_prod;
    logic [NUMW-1:0]           r_num;
    logic                      r_sat;
    logic [RATE_W-1:0]         r_rate;
    logic signed [CORR_W-1:0]  r_corr;

    // timing state
    logic [SEQ_BITS-1:0]       r_base;
    logic                      r_base_valid;
    logic [TIME_W-1:0]         r_next;

    // output register
    logic                      r_out_valid;
    logic [TIME_W-1:0]         r_o_next;
    logic signed [CORR_W-1:0]  r_o_corr;
    logic                      r_o_sched;
    logic [RATE_W-1:0]         r_o_rate;

    logic                      div_start;
    logic                      div_busy;
    logic [pdts_pkg::STEP_W-1:0] div_steps;
    logic [DEN_W-1:0]          div_rem_init;
    logic [QW-1:0]             div_quo_init;
    logic [DEN_W-1:0]          div_dvs;
    logic [QW-1:0]             div_quo;

    logic [SEQ_BITS-1:0]       seq_span;
    logic [IV_W-1:0]           iv_now;
    logic [DEN_W-1:0]          den;
    logic [CMPW-1:0]           hi_ext;
    logic [CMPW-1:0]           den_ext;

    pdts_pkg::t_band           band;
    logic [IV_W:0]             x3;
    logic [P3W-1:0]            prod3;
    logic [IV_W-1:0]           third;
    logic [IV_W+1:0]           three_iv;
    logic [IV_W-1:0]           mag;
    logic                      neg;
    logic [SEQ_BITS-1:0]       gap;
    logic                      allow;
    logic signed [CORR_W-1:0]  corr_val;

    logic [TIME_W-1:0]         iv32;
    logic [TIME_W-1:0]         corr32;
    logic [TIME_W-1:0]         t_sum;
    logic [TIME_W-1:0]         t_fix;
    logic                      no_rate;
    logic                      out_free;

    assign seq_span = i_newest_seq - i_current_seq;
    assign iv_now   = (i_fps == '0) ? '0 : div_quo[IV_W-1:0];
    assign den      = DEN_W'(r_interval) + DEN_W'(i_delay);
    assign hi_ext   = CMPW'(r_num[NUMW-1:FRAC]);
    assign den_ext  = CMPW'(den);

    // one divider serves the frame interval and the buffered rate
    assign div_start    = i_cmd.iv_start | i_cmd.rate_start;
    assign div_steps    = i_cmd.iv_start ? pdts_pkg::IV_STEPS : pdts_pkg::RATE_STEPS;
    assign div_rem_init = i_cmd.iv_start ? '0 : hi_ext[DEN_W-1:0];
    assign div_quo_init = i_cmd.iv_start ? pdts_pkg::US_PER_S
                                         : {r_num[FRAC-1:0], {(QW-FRAC){1'b0}}};
    assign div_dvs      = i_cmd.iv_start ? DEN_W'(i_fps) : den;

    pdts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_rem_init (div_rem_init),
        .i_quo_init (div_quo_init),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quo      (div_quo)
    );

    // correction band
    assign band     = pdts_pkg::band_of(r_fill);
    assign x3       = (band == pdts_pkg::B_DN23) ? {r_interval, 1'b0} : {1'b0, r_interval};
    assign prod3    = P3W'(x3) * P3W'(pdts_pkg::RECIP3);
    assign third    = prod3[pdts_pkg::RECIP3_SH +: IV_W];
    assign three_iv = {2'b00, r_interval} + {1'b0, r_interval, 1'b0};

    always_comb begin
        mag = '0;
        neg = 1'b0;
        unique case (band)
            pdts_pkg::B_UP1:  mag = r_interval;
            pdts_pkg::B_UP2:  mag = r_interval >> 1;
            pdts_pkg::B_UP3:  mag = third;
            pdts_pkg::B_UP4:  mag = r_interval >> 2;
            pdts_pkg::B_UP8:  mag = r_interval >> 3;
            pdts_pkg::B_HOLD: mag = '0;
            pdts_pkg::B_DN8: begin
                mag = r_interval >> 3;
                neg = 1'b1;
            end
            pdts_pkg::B_DN4: begin
                mag = r_interval >> 2;
                neg = 1'b1;
            end
            pdts_pkg::B_DN3, pdts_pkg::B_DN23: begin
                mag = third;
                neg = 1'b1;
            end
            pdts_pkg::B_DN34: begin
                mag = three_iv[IV_W+1:2];
                neg = 1'b1;
            end
            default: begin
                mag = '0;
                neg = 1'b0;
            end
        endcase
    end

    // a correction needs a valid frame and more than two frames since the last one
    assign gap      = r_cur - r_base;
    assign allow    = r_cur_valid &&
                      (!r_base_valid ||
                       (!gap[SEQ_BITS-1] && (gap > SEQ_BITS'(pdts_pkg::MIN_GAP))));
    assign corr_val = !allow ? '0 : (neg ? -CORR_W'(mag) : CORR_W'(mag));

    // next decode time, folded to 1 near the top of the time range
    assign iv32    = TIME_W'(r_interval);
    assign corr32  = {{(TIME_W-CORR_W){r_corr[CORR_W-1]}}, r_corr};
    assign t_sum   = r_present + iv32 + corr32;
    assign t_fix   = (t_sum > ~iv32) ? TIME_W'(1) : t_sum;
    assign no_rate = (r_next == '0) && (r_interval == '0);

    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_restart   <= i_restart;
            r_present   <= i_present_time_us;
            r_cur       <= i_current_seq;
            r_cur_valid <= i_current_seq_valid;
            r_fill      <= i_fill_rate_in;
            r_dmag      <= seq_span[DMW-1:0];
            r_rate_zero <= (i_delay == '0) || !i_current_seq_valid || seq_span[SEQ_BITS-1];
        end
        if (i_cmd.mul) begin
            r_interval <= iv_now;
            r_prod     <= PRW'(r_dmag) * PRW'(iv_now);
        end
        if (i_cmd.scale) begin
            r_num <= (NUMW'(r_prod) << 6) + (NUMW'(r_prod) << 5) + (NUMW'(r_prod) << 2);
        end
        if (i_cmd.rate_start) begin
            r_sat <= (hi_ext >= den_ext);
        end
        if (i_cmd.corr) begin
            r_rate <= r_rate_zero ? '0 : (r_sat ? pdts_pkg::RATE_SAT : div_quo[RATE_W-1:0]);
            r_corr <= corr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_base_valid <= 1'b0;
            r_next       <= '0;
        end else if (i_cmd.commit) begin
            if (r_restart) begin
                r_base       <= '0;
                r_base_valid <= 1'b0;
                r_next       <= '0;
            end else if (!no_rate) begin
                r_next <= t_fix;
                if (r_corr != '0) begin
                    r_base       <= r_cur;
                    r_base_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_rate <= r_rate;
            if (r_restart) begin
                r_o_next  <= '0;
                r_o_corr  <= '0;
                r_o_sched <= 1'b0;
            end else if (no_rate) begin
                r_o_next  <= r_next;
                r_o_corr  <= '0;
                r_o_sched <= 1'b0;
            end else begin
                r_o_next  <= t_fix;
                r_o_corr  <= r_corr;
                r_o_sched <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_time_us  = r_o_next;
    assign o_correction_us = r_o_corr;
    assign o_scheduled     = r_o_sched;
    assign o_fill_rate_out = r_o_rate;

endmodule

FILE: sv/playout_decode_time_scheduler.sv
// Playout decode-time scheduler.
// Input channel (i_in_valid / o_in_stall) takes one item per video frame:
// restart flag, present time, processing and newest sequence numbers and the
// fill rate that picks the correction band. The output channel
// (o_out_valid / i_out_stall) returns one item per input item: next decode
// time, correction applied, scheduled flag and the measured buffered rate.
// Configuration goes through the APB port: byte address 0 holds the frame
// rate, address 4 the target delay in microseconds.
// Each item passes the interval division, multiply, scale, rate division,
// correction and scheduling states; a new item is accepted only after the
// previous one is committed. The shared serial divider takes 20 steps for the
// frame interval, 16 for the buffered rate, one quotient bit per cycle.
// While the receiver stalls, the finished item waits in the output register
// and the next item is processed up to the final step, then held.
// Reset clears the timing state, the frame rate and the target delay; the
// block accepts items in the first cycle after reset.
module playout_decode_time_scheduler #(
    parameter int SEQ_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pdts_pkg::ADDR_W-1:0]          paddr,
    input  logic [pdts_pkg::DATA_W-1:0]          pwdata,
    output logic [pdts_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_restart,
    input  logic [pdts_pkg::TIME_W-1:0]          i_present_time_us,
    input  logic [SEQ_BITS-1:0]                  i_current_seq,
    input  logic                                 i_current_seq_valid,
    input  logic [SEQ_BITS-1:0]                  i_newest_seq,
    input  logic [pdts_pkg::RATE_W-1:0]          i_fill_rate_in,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [pdts_pkg::TIME_W-1:0]          o_next_time_us,
    output logic signed [pdts_pkg::CORR_W-1:0]   o_correction_us,
    output logic                                 o_scheduled,
    output logic [pdts_pkg::RATE_W-1:0]          o_fill_rate_out
);

    logic [pdts_pkg::FPS_W-1:0] r_fps;
    logic [pdts_pkg::DLY_W-1:0] r_delay;
    logic                       wr_en;
    pdts_pkg::t_reg_idx         reg_idx;
    pdts_pkg::t_cmd             w_cmd;
    pdts_pkg::t_stat            w_stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = pdts_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps   <= '0;
            r_delay <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                pdts_pkg::REG_FPS: begin
                    // a zero frame rate leaves the interval as it was
                    if (pwdata[pdts_pkg::FPS_W-1:0] != '0) begin
                        r_fps <= pwdata[pdts_pkg::FPS_W-1:0];
                    end
                end
                pdts_pkg::REG_DELAY: r_delay <= pwdata[pdts_pkg::DLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pdts_pkg::REG_FPS:   prdata = pdts_pkg::DATA_W'(r_fps);
            pdts_pkg::REG_DELAY: prdata = pdts_pkg::DATA_W'(r_delay);
            default:             prdata = '0;
        endcase
    end

    pdts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    pdts_dpath #(
        .SEQ_BITS (SEQ_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_fps               (r_fps),
        .i_delay             (r_delay),
        .i_restart           (i_restart),
        .i_present_time_us   (i_present_time_us),
        .i_current_seq       (i_current_seq),
        .i_current_seq_valid (i_current_seq_valid),
        .i_newest_seq        (i_newest_seq),
        .i_fill_rate_in      (i_fill_rate_in),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_next_time_us      (o_next_time_us),
        .o_correction_us     (o_correction_us),
        .o_scheduled         (o_scheduled),
        .o_fill_rate_out     (o_fill_rate_out)
    );

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input accepted while previous item still in work");

    a_no_corr_unscheduled: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_scheduled) |-> (o_correction_us == '0)
    ) else $error("correction reported on an unscheduled item");

    a_commit_into_free_slot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || !i_out_stall)
    ) else $error("result written over a stalled output item");

    a_stall_released_by_commit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> (!o_in_stall && o_out_valid)
    ) else $error("commit did not release input and present the result");

endmodule
